// ===== rtl/core/bva_pkg.sv =====
`timescale 1ns / 1ps
package bva_pkg;

    localparam int OpW     = 4;
    localparam int DataW   = 32;
    localparam int SliceW  = 5;
    localparam int WidthDefault = 32;
    localparam int QueueDepth   = 2;

    typedef enum logic [OpW-1:0] {
        OP_AND   = 4'd0,
        OP_NOT   = 4'd1,
        OP_ULT   = 4'd2,
        OP_EQ    = 4'd3,
        OP_ADD   = 4'd4,
        OP_SLL   = 4'd5,
        OP_SRL   = 4'd6,
        OP_MUL   = 4'd7,
        OP_UDIV  = 4'd8,
        OP_UREM  = 4'd9,
        OP_SLICE = 4'd10,
        OP_COND  = 4'd11
    } t_opcode;

    // work class picked by the front end
    typedef enum logic [1:0] {
        CL_SIMPLE = 2'd0,
        CL_MUL    = 2'd1,
        CL_DIV    = 2'd2
    } t_class;

endpackage

// ===== rtl/core/bva_front.sv =====
`timescale 1ns / 1ps
module bva_front
    import bva_pkg::*;
#(
    parameter int WIDTH = WidthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OpW-1:0]    i_opcode,
    input  logic [DataW-1:0]  i_operand_a,
    input  logic [DataW-1:0]  i_operand_b,
    input  logic              i_cond_bit,
    input  logic [SliceW-1:0] i_slice_upper,
    input  logic [SliceW-1:0] i_slice_lower,
    output logic              o_valid,
    input  logic              i_ready,
    output t_class            o_class,
    output logic              o_rem,
    output logic [WIDTH-1:0]  o_a,
    output logic [WIDTH-1:0]  o_b,
    output logic [WIDTH-1:0]  o_simple
);
    localparam int ShW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int Ext = (WIDTH > DataW) ? WIDTH - DataW : 0;

    logic [WIDTH-1:0] a, b, simple;
    logic [ShW-1:0]   amt;
    logic [6:0]       up, lo;
    logic [WIDTH-1:0] sl_mask;
    t_class           cls;

    logic             r_valid;
    t_class           r_class;
    logic             r_rem;
    logic [WIDTH-1:0] r_a, r_b, r_simple;

    generate
        if (WIDTH > DataW) begin : g_wide
            assign a = {{Ext{1'b0}}, i_operand_a};
            assign b = {{Ext{1'b0}}, i_operand_b};
        end else begin : g_narrow
            assign a = i_operand_a[WIDTH-1:0];
            assign b = i_operand_b[WIDTH-1:0];
        end
    endgenerate

    assign amt = b[ShW-1:0];

    always_comb begin
        up = {2'b00, i_slice_upper};
        lo = {2'b00, i_slice_lower};
        if (up >= 7'(WIDTH)) up = 7'(WIDTH - 1);
        for (int i = 0; i < WIDTH; i++) sl_mask[i] = (7'(i) <= up - lo);
        simple = '0;
        cls    = CL_SIMPLE;
        unique case (i_opcode) inside
            OP_AND:  simple = a & b;
            OP_NOT:  simple = ~a;
            OP_ULT:  simple = WIDTH'(a < b);
            OP_EQ:   simple = WIDTH'(a == b);
            OP_ADD:  simple = a + b;
            OP_SLL:  simple = ({1'b0, amt} >= (ShW+1)'(WIDTH)) ? '0 : a << amt;
            OP_SRL:  simple = ({1'b0, amt} >= (ShW+1)'(WIDTH)) ? '0 : a >> amt;
            OP_MUL:  cls = CL_MUL;
            OP_UDIV, OP_UREM: cls = CL_DIV;
            OP_SLICE: simple = (lo > up) ? '0 : (a >> lo[ShW-1:0]) & sl_mask;
            OP_COND: simple = i_cond_bit ? a : b;
            default: simple = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_class  <= cls;
            r_rem    <= (i_opcode == OP_UREM);
            r_a      <= a;
            r_b      <= b;
            r_simple <= simple;
        end
    end

    assign o_valid  = r_valid;
    assign o_class  = r_class;
    assign o_rem    = r_rem;
    assign o_a      = r_a;
    assign o_b      = r_b;
    assign o_simple = r_simple;
endmodule

// ===== rtl/core/bva_queue.sv =====
`timescale 1ns / 1ps
module bva_queue
    import bva_pkg::*;
#(
    parameter int WIDTH = WidthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_class           i_class,
    input  logic             i_rem,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_simple,
    output logic             o_valid,
    input  logic             i_ready,
    output t_class           o_class,
    output logic             o_rem,
    output logic [WIDTH-1:0] o_a,
    output logic [WIDTH-1:0] o_b,
    output logic [WIDTH-1:0] o_simple
);
    typedef struct packed {
        t_class           cls;
        logic             rem;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] simple;
    } t_entry;

    t_entry     r_mem [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'(QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_mem[r_wp] <= '{i_class, i_rem, i_a, i_b, i_simple};
    end

    assign o_class  = r_mem[r_rp].cls;
    assign o_rem    = r_mem[r_rp].rem;
    assign o_a      = r_mem[r_rp].a;
    assign o_b      = r_mem[r_rp].b;
    assign o_simple = r_mem[r_rp].simple;
endmodule

// ===== rtl/core/bva_back.sv =====
`timescale 1ns / 1ps
module bva_back
    import bva_pkg::*;
#(
    parameter int WIDTH = WidthDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_class           i_class,
    input  logic             i_rem,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_simple,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_result
);
    // stage 0 takes the item, stages 1..WIDTH do one restoring divide step each,
    // multiply adds one shifted copy of a per stage for one bit of b (one add)
    localparam int N = WIDTH;

    logic             r_v   [N+1];
    t_class           r_cls [N+1];
    logic             r_rem [N+1];
    logic [WIDTH-1:0] r_a   [N+1];
    logic [WIDTH-1:0] r_b   [N+1];
    logic [WIDTH-1:0] r_q   [N+1];
    logic [WIDTH:0]   r_r   [N+1];
    logic [WIDTH-1:0] r_acc [N+1];
    logic [WIDTH-1:0] r_sim [N+1];
    logic             adv;

    assign adv     = !r_v[N] || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= N; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= N; s++) r_v[s] <= r_v[s-1];
        end
        if (adv) begin
            r_cls[0] <= i_class;
            r_rem[0] <= i_rem;
            r_a[0]   <= i_a;
            r_b[0]   <= i_b;
            r_q[0]   <= i_a;
            r_r[0]   <= '0;
            r_acc[0] <= '0;
            r_sim[0] <= i_simple;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= N; g++) begin : g_stage
            logic [WIDTH:0]   sh, diff;
            logic [WIDTH-1:0] acc;
            always_comb begin
                sh   = {r_r[g-1][WIDTH-1:0], r_q[g-1][WIDTH-1]};
                diff = sh - {1'b0, r_b[g-1]};
                acc  = r_acc[g-1];
                // multiply bit g-1 of b, shift-and-add one bit per stage
                if (r_b[g-1][g-1]) acc = acc + (r_a[g-1] << (g-1));
            end
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_cls[g] <= r_cls[g-1];
                    r_rem[g] <= r_rem[g-1];
                    r_a[g]   <= r_a[g-1];
                    r_b[g]   <= r_b[g-1];
                    r_sim[g] <= r_sim[g-1];
                    r_acc[g] <= acc;
                    if (!diff[WIDTH]) begin
                        r_r[g] <= diff;
                        r_q[g] <= {r_q[g-1][WIDTH-2:0], 1'b1};
                    end else begin
                        r_r[g] <= sh;
                        r_q[g] <= {r_q[g-1][WIDTH-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // divide by zero falls out of restoring steps: quotient all ones, remainder a
    always_comb begin
        case (r_cls[N])
            CL_MUL:  o_result = r_acc[N];
            CL_DIV:  o_result = r_rem[N] ? r_r[N][WIDTH-1:0] : r_q[N];
            default: o_result = r_sim[N];
        endcase
    end

    assign o_valid = r_v[N];
endmodule

// ===== rtl/core/bitvector_alu_core.sv =====
`timescale 1ns / 1ps
// path: input passes the front register, the queue, the back input stage and
// WIDTH divide/multiply step stages before it reaches the result
// throughput: one item per cycle; the back pipeline holds when the result stalls
// reset: synchronous active-low reset empties all stages and the queue
module bitvector_alu_core
    import bva_pkg::*;
#(
    parameter int WIDTH = WidthDefault
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OpW-1:0]    i_opcode,
    input  logic [DataW-1:0]  i_operand_a,
    input  logic [DataW-1:0]  i_operand_b,
    input  logic              i_cond_bit,
    input  logic [SliceW-1:0] i_slice_upper,
    input  logic [SliceW-1:0] i_slice_lower,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DataW-1:0]  o_result
);
    logic             f_v, f_r, q_v, q_r;
    t_class           f_cls, q_cls;
    logic             f_rem, q_rem;
    logic [WIDTH-1:0] f_a, f_b, f_s, q_a, q_b, q_s, res;

    bva_front #(.WIDTH(WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_opcode, .i_operand_a, .i_operand_b, .i_cond_bit,
        .i_slice_upper, .i_slice_lower,
        .o_valid(f_v), .i_ready(f_r), .o_class(f_cls), .o_rem(f_rem),
        .o_a(f_a), .o_b(f_b), .o_simple(f_s)
    );

    bva_queue #(.WIDTH(WIDTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_class(f_cls), .i_rem(f_rem),
        .i_a(f_a), .i_b(f_b), .i_simple(f_s),
        .o_valid(q_v), .i_ready(q_r), .o_class(q_cls), .o_rem(q_rem),
        .o_a(q_a), .o_b(q_b), .o_simple(q_s)
    );

    bva_back #(.WIDTH(WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_class(q_cls), .i_rem(q_rem),
        .i_a(q_a), .i_b(q_b), .i_simple(q_s),
        .o_valid, .i_ready, .o_result(res)
    );

    generate
        if (WIDTH >= DataW) begin : g_wide
            assign o_result = res[DataW-1:0];
        end else begin : g_narrow
            assign o_result = {{(DataW-WIDTH){1'b0}}, res};
        end
    endgenerate
endmodule

// ===== tb/sv/bitvector_alu_core_test.sv =====
`timescale 1ns / 1ps
module bitvector_alu_core_test;
    import bva_pkg::*;

    localparam int W = WidthDefault;
    localparam int ShBits = $clog2(W);
    localparam longint CycleLimit = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [OpW-1:0]    i_opcode = '0;
    logic [DataW-1:0]  i_operand_a = '0;
    logic [DataW-1:0]  i_operand_b = '0;
    logic              i_cond_bit = 1'b0;
    logic [SliceW-1:0] i_slice_upper = '0;
    logic [SliceW-1:0] i_slice_lower = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [DataW-1:0]  o_result;

    logic [DataW-1:0] expected_results[$];
    int  n_errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  hold_off = 0;
    longint n_cycles = 0;
    bit  op_seen[16];

    bitvector_alu_core #(.WIDTH(W)) u_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [DataW-1:0] alu_result(logic [3:0] op, logic [DataW-1:0] a,
                                                    logic [DataW-1:0] b, logic cb,
                                                    logic [4:0] up, logic [4:0] lo);
        logic [63:0] m;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] r;
        int amt;
        int u;
        m = (W >= 64) ? '1 : ((64'd1 << W) - 1);
        ma = {32'd0, a} & m;
        mb = {32'd0, b} & m;
        r = '0;
        u = up;
        amt = int'(mb & ((64'd1 << ShBits) - 1));
        case (op)
            OP_AND:  r = ma & mb;
            OP_NOT:  r = ~ma;
            OP_ULT:  r = (ma < mb) ? 64'd1 : 64'd0;
            OP_EQ:   r = (ma == mb) ? 64'd1 : 64'd0;
            OP_ADD:  r = ma + mb;
            OP_SLL:  r = (amt >= W) ? 64'd0 : ma << amt;
            OP_SRL:  r = (amt >= W) ? 64'd0 : ma >> amt;
            OP_MUL:  r = ma * mb;
            OP_UDIV: r = (mb == 0) ? m : ma / mb;
            OP_UREM: r = (mb == 0) ? ma : ma % mb;
            OP_SLICE: begin
                if (u >= W) u = W - 1;
                if (lo > u) r = '0;
                else r = (ma >> lo) & ((64'd1 << (u - lo + 1)) - 1);
            end
            OP_COND: r = cb ? ma : mb;
            default: r = '0;
        endcase
        return DataW'(r & m);
    endfunction

    task automatic report_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // one transfer into the block; valid stays up across back-to-back items
    task automatic send_item(logic [3:0] op, logic [DataW-1:0] a, logic [DataW-1:0] b,
                             logic cb, logic [4:0] up, logic [4:0] lo);
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_operand_a   <= a;
        i_operand_b   <= b;
        i_cond_bit    <= cb;
        i_slice_upper <= up;
        i_slice_lower <= lo;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(alu_result(op, a, b, cb, up, lo));
        op_seen[op] = 1'b1;
        n_items++;
    endtask

    task automatic go_idle(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [DataW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return DataW'($urandom_range(0, 40));
            3: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_AND, '1, 32'h5a5a_a5a5, 1'b0, 5'd0, 5'd0);
        send_item(OP_NOT, '0, '0, 1'b1, 5'd31, 5'd31);
        send_item(OP_NOT, '1, '1, 1'b0, 5'd0, 5'd0);
        send_item(OP_ULT, 32'd3, 32'd4, 1'b0, 5'd0, 5'd0);
        send_item(OP_ULT, '1, '1, 1'b0, 5'd0, 5'd0);
        send_item(OP_EQ, '1, '1, 1'b0, 5'd0, 5'd0);
        send_item(OP_EQ, '0, 32'd1, 1'b0, 5'd0, 5'd0);
        send_item(OP_ADD, '1, 32'd1, 1'b0, 5'd0, 5'd0);
        send_item(OP_SLL, '1, 32'hffff_ffe1, 1'b0, 5'd0, 5'd0);
        send_item(OP_SLL, 32'h8000_0001, 32'd31, 1'b0, 5'd0, 5'd0);
        send_item(OP_SRL, '1, 32'd31, 1'b0, 5'd0, 5'd0);
        send_item(OP_SRL, 32'h1234_5678, 32'd32, 1'b0, 5'd0, 5'd0);
        send_item(OP_MUL, '1, '1, 1'b0, 5'd0, 5'd0);
        send_item(OP_UDIV, '1, 32'd1, 1'b0, 5'd0, 5'd0);
        // divide by zero
        send_item(OP_UDIV, 32'h1234_5678, '0, 1'b0, 5'd0, 5'd0);
        send_item(OP_UREM, 32'h1234_5678, '0, 1'b0, 5'd0, 5'd0);
        send_item(OP_UREM, '1, 32'd7, 1'b0, 5'd0, 5'd0);
        send_item(OP_SLICE, '1, '0, 1'b0, 5'd31, 5'd0);
        send_item(OP_SLICE, 32'hdead_beef, '0, 1'b0, 5'd15, 5'd4);
        // reversed slice bounds
        send_item(OP_SLICE, '1, '0, 1'b0, 5'd3, 5'd9);
        send_item(OP_COND, 32'haaaa_aaaa, 32'h5555_5555, 1'b1, 5'd0, 5'd0);
        send_item(OP_COND, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 5'd0, 5'd0);
        send_item(4'd12, '1, '1, 1'b1, 5'd31, 5'd31);
        send_item(4'd15, '1, '1, 1'b1, 5'd31, 5'd0);
        go_idle(1);
    endtask

    task automatic test_random(int count);
        int burst;
        for (int i = 0; i < count; ) begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst && i < count; j++, i++) begin
                send_item(4'($urandom_range(0, 15)), rand_operand(), rand_operand(),
                          1'($urandom), 5'($urandom), 5'($urandom));
            end
            if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 6));
        end
        go_idle(1);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        hold_off = 120;
        for (int i = 0; i < 80; i++) begin
            send_item(4'($urandom_range(0, 11)), $urandom, $urandom, 1'($urandom),
                      5'($urandom), 5'($urandom));
        end
        go_idle(1);
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            i_ready  <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (n_cycles % 400 < 150) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result, '0);
            end else begin
                logic [DataW-1:0] want;
                want = expected_results.pop_front();
                if (o_result !== want) report_mismatch("result", o_result, want);
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CycleLimit) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int ops_hit;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_random(420);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (W + 10) @(posedge i_clk);
        ops_hit = 0;
        foreach (op_seen[k]) ops_hit += op_seen[k];
        $display("sent %0d items over %0d opcodes, checked %0d results, %0d errors",
                 n_items, ops_hit, n_results, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
